### sv/ptc_pkg.sv
package ptc_pkg;

  // Configuration register map (byte address = 8 * index)
  localparam int unsigned PADDR_W = 5;
  localparam int unsigned PDATA_W = 64;
  localparam logic [1:0]  REG_CAL_T  = 2'd0;
  localparam logic [1:0]  REG_CAL_PA = 2'd1;
  localparam logic [1:0]  REG_CAL_PB = 2'd2;
  localparam logic [1:0]  REG_CAL_PC = 2'd3;

  // Field widths
  localparam int unsigned RAW_W   = 20;
  localparam int unsigned FINE_W  = 32;
  localparam int unsigned CENTI_W = 24;
  localparam int unsigned PRES_W  = 32;

  // Arithmetic constants
  localparam logic [63:0] FINE_OFFSET = 64'd128000;
  localparam logic [63:0] PRES_SCALE  = 64'd3125;
  localparam logic [20:0] RAW_FULL    = 21'd1048576;
  localparam logic [63:0] V1_BIAS     = 64'h0000_8000_0000_0000;
  localparam logic [31:0] CENTI_ROUND = 32'd128;

  // Pipeline timing
  localparam int unsigned MUL_LAT    = 2;
  localparam int unsigned DIV_LAT    = 66;
  localparam int unsigned PIPE_DEPTH = 85;

  function automatic logic [63:0] sx16(input logic [15:0] v);
    sx16 = {{48{v[15]}}, v};
  endfunction

endpackage

### sv/ptc_ifs.sv
interface ptc_sample_if;
  logic                           valid;
  logic                           ready;
  logic [ptc_pkg::RAW_W-1:0]      raw_temperature;
  logic [ptc_pkg::RAW_W-1:0]      raw_pressure;

  modport source(output valid, raw_temperature, raw_pressure, input ready);
  modport sink(input valid, raw_temperature, raw_pressure, output ready);
endinterface

interface ptc_result_if;
  logic                               valid;
  logic                               ready;
  logic signed [ptc_pkg::FINE_W-1:0]  fine_temperature;
  logic signed [ptc_pkg::CENTI_W-1:0] temperature_centi;
  logic [ptc_pkg::PRES_W-1:0]         pressure_q24_8;
  logic                               pressure_valid;

  modport source(output valid, fine_temperature, temperature_centi, pressure_q24_8,
                 pressure_valid, input ready);
  modport sink(input valid, fine_temperature, temperature_centi, pressure_q24_8,
               pressure_valid, output ready);
endinterface

### sv/ptc_delay.sv
module ptc_delay #(
  parameter int unsigned W = 1,
  parameter int unsigned N = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] taps [N];

  always_ff @(posedge clk) begin
    if (en) begin
      taps[0] <= d;
      for (int i = 1; i < N; i++) begin
        taps[i] <= taps[i-1];
      end
    end
  end

  assign q = taps[N-1];

endmodule

### sv/ptc_mul64.sv
module ptc_mul64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] a,
  input  logic [63:0] b,
  output logic [63:0] p
);

  logic [63:0] ll_c;
  logic [31:0] lh_c;
  logic [31:0] hl_c;
  logic [63:0] ll;
  logic [31:0] lh;
  logic [31:0] hl;

  // Low 64 bits only: the high-by-high partial product never reaches them
  assign ll_c = a[31:0] * b[31:0];
  assign lh_c = a[31:0] * b[63:32];
  assign hl_c = a[63:32] * b[31:0];

  always_ff @(posedge clk) begin
    if (en) begin
      ll <= ll_c;
      lh <= lh_c;
      hl <= hl_c;
      p  <= ll + {lh + hl, 32'b0};
    end
  end

endmodule

### sv/ptc_div64.sv
module ptc_div64 (
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] num,
  input  logic [63:0] den,
  output logic [63:0] quo
);

  logic [63:0] rem_q [65];
  logic [63:0] nq_q  [65];
  logic [63:0] den_q [65];
  logic        neg_q [65];

  // Take magnitudes, remember the quotient sign
  always_ff @(posedge clk) begin
    if (en) begin
      rem_q[0] <= '0;
      nq_q[0]  <= num[63] ? 64'(0 - num) : num;
      den_q[0] <= den[63] ? 64'(0 - den) : den;
      neg_q[0] <= num[63] ^ den[63];
    end
  end

  // One quotient bit per stage, restoring
  for (genvar s = 1; s <= 64; s++) begin : g_bit
    logic [64:0] rsh;
    logic        take;
    assign rsh  = {rem_q[s-1], nq_q[s-1][63]};
    assign take = rsh >= {1'b0, den_q[s-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= take ? 64'(rsh - {1'b0, den_q[s-1]}) : rsh[63:0];
        nq_q[s]  <= {nq_q[s-1][62:0], take};
        den_q[s] <= den_q[s-1];
        neg_q[s] <= neg_q[s-1];
      end
    end
  end

  // Apply sign; truncation toward zero
  always_ff @(posedge clk) begin
    if (en) begin
      quo <= neg_q[64] ? 64'(0 - nq_q[64]) : nq_q[64];
    end
  end

endmodule

### sv/ptc_temp.sv
module ptc_temp (
  input  logic                               clk,
  input  logic                               en,
  input  logic [ptc_pkg::RAW_W-1:0]          raw_temperature,
  input  logic [47:0]                        cal,
  output logic [ptc_pkg::FINE_W-1:0]         fine,
  output logic [ptc_pkg::CENTI_W-1:0]        centi
);

  logic [31:0] t1;
  logic [31:0] t2;
  logic [31:0] t3;
  logic [31:0] x;
  logic [31:0] d;
  logic [31:0] px;
  logic [31:0] dd;
  logic [31:0] dd_sh;
  logic [31:0] a;
  logic [31:0] pb;
  logic [31:0] f5;
  logic [31:0] f5_sh;

  assign t1 = {16'b0, cal[15:0]};
  assign t2 = {{16{cal[31]}}, cal[31:16]};
  assign t3 = {{16{cal[47]}}, cal[47:32]};

  assign dd_sh = 32'($signed(dd) >>> 12);
  assign f5    = (fine << 2) + fine + ptc_pkg::CENTI_ROUND;
  assign f5_sh = 32'($signed(f5) >>> 8);

  always_ff @(posedge clk) begin
    if (en) begin
      x     <= {15'b0, raw_temperature[19:3]} - {t1[30:0], 1'b0};
      d     <= {16'b0, raw_temperature[19:4]} - t1;
      px    <= x * t2;
      dd    <= d * d;
      a     <= 32'($signed(px) >>> 11);
      pb    <= dd_sh * t3;
      fine  <= a + 32'($signed(pb) >>> 14);
      centi <= f5_sh[23:0];
    end
  end

endmodule

### sv/pressure_temperature_compensation_unit.sv
// Throughput: one conversion pair per cycle; the 64-stage pipelined divider
//   sets the depth, the 32x32 partial-product multipliers set the stage length.
// Stall: the whole pipeline holds while a result waits and the sink is not ready.
// Reset (rst, synchronous): clears all pipeline valid bits and the four
//   calibration registers to zero.
module pressure_temperature_compensation_unit (
  input  logic                          clk,
  input  logic                          rst,
  ptc_sample_if.sink                    sample,
  ptc_result_if.source                  result,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ptc_pkg::PADDR_W-1:0]   paddr,
  input  logic [ptc_pkg::PDATA_W-1:0]   pwdata,
  output logic [ptc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  // ---------------------------------------------------------------------
  // Calibration registers
  // ---------------------------------------------------------------------
  logic [47:0] cal_t;
  logic [63:0] cal_pa;
  logic [63:0] cal_pb;
  logic [15:0] cal_pc;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cal_t  <= '0;
      cal_pa <= '0;
      cal_pb <= '0;
      cal_pc <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        ptc_pkg::REG_CAL_T:  cal_t  <= pwdata[47:0];
        ptc_pkg::REG_CAL_PA: cal_pa <= pwdata;
        ptc_pkg::REG_CAL_PB: cal_pb <= pwdata;
        ptc_pkg::REG_CAL_PC: cal_pc <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      ptc_pkg::REG_CAL_T:  prdata = {16'b0, cal_t};
      ptc_pkg::REG_CAL_PA: prdata = cal_pa;
      ptc_pkg::REG_CAL_PB: prdata = cal_pb;
      ptc_pkg::REG_CAL_PC: prdata = {48'b0, cal_pc};
      default:             prdata = '0;
    endcase
  end

  // Calibration words; the user must keep them stable while items are in flight (not enforced here)
  logic [63:0] p1, p2, p3, p4, p5, p6, p7, p8, p9;
  assign p1 = {48'b0, cal_pa[15:0]};
  assign p2 = ptc_pkg::sx16(cal_pa[31:16]);
  assign p3 = ptc_pkg::sx16(cal_pa[47:32]);
  assign p4 = ptc_pkg::sx16(cal_pa[63:48]);
  assign p5 = ptc_pkg::sx16(cal_pb[15:0]);
  assign p6 = ptc_pkg::sx16(cal_pb[31:16]);
  assign p7 = ptc_pkg::sx16(cal_pb[47:32]);
  assign p8 = ptc_pkg::sx16(cal_pb[63:48]);
  assign p9 = ptc_pkg::sx16(cal_pc);

  // ---------------------------------------------------------------------
  // Flow control: one global advance; valid bits travel with the data
  // ---------------------------------------------------------------------
  logic                        adv;
  logic [ptc_pkg::PIPE_DEPTH:1] vld;

  assign adv          = !vld[ptc_pkg::PIPE_DEPTH] || result.ready;
  assign sample.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[ptc_pkg::PIPE_DEPTH-1:1], sample.valid};
    end
  end

  // ---------------------------------------------------------------------
  // Temperature: fine at stage 4, centi at stage 5
  // ---------------------------------------------------------------------
  logic [31:0] fine4;
  logic [23:0] centi5;

  ptc_temp u_temp (
    .clk             (clk),
    .en              (adv),
    .raw_temperature (sample.raw_temperature),
    .cal             (cal_t),
    .fine            (fine4),
    .centi           (centi5)
  );

  // ---------------------------------------------------------------------
  // Pressure, 64-bit wrapping math
  // ---------------------------------------------------------------------
  logic [63:0] v1;        // stage 5
  logic [63:0] vv;        // stage 7
  logic [63:0] v1p5;
  logic [63:0] v1p2;
  logic [63:0] vvp6;      // stage 9
  logic [63:0] vvp3;
  logic [63:0] v1p5_d;
  logic [63:0] v1p2_d;
  logic [63:0] v2;        // stage 10
  logic [63:0] v1b;
  logic [19:0] rp10;
  logic [20:0] pbase;
  logic [63:0] num_pre;   // stage 11
  logic [63:0] v1c_prod;  // stage 12
  logic [63:0] den;       // stage 13
  logic [63:0] num;
  logic        zero84;
  logic [63:0] q;         // stage 79
  logic [63:0] h;
  logic [63:0] hh;        // stage 81
  logic [63:0] w2;
  logic [63:0] w1;        // stage 83
  logic [63:0] w2_d;
  logic [63:0] q_d;
  logic [63:0] s84;       // stage 84
  logic [63:0] s_sh;
  logic [31:0] pres;      // stage 85
  logic        pvalid;

  always_ff @(posedge clk) begin
    if (adv) begin
      v1 <= {{32{fine4[31]}}, fine4} - ptc_pkg::FINE_OFFSET;
    end
  end

  ptc_mul64 u_mul_vv  (.clk(clk), .en(adv), .a(v1), .b(v1), .p(vv));
  ptc_mul64 u_mul_p5  (.clk(clk), .en(adv), .a(v1), .b(p5), .p(v1p5));
  ptc_mul64 u_mul_p2  (.clk(clk), .en(adv), .a(v1), .b(p2), .p(v1p2));
  ptc_mul64 u_mul_p6  (.clk(clk), .en(adv), .a(vv), .b(p6), .p(vvp6));
  ptc_mul64 u_mul_p3  (.clk(clk), .en(adv), .a(vv), .b(p3), .p(vvp3));

  ptc_delay #(.W(64), .N(2)) u_dly_p5 (.clk(clk), .en(adv), .d(v1p5), .q(v1p5_d));
  ptc_delay #(.W(64), .N(2)) u_dly_p2 (.clk(clk), .en(adv), .d(v1p2), .q(v1p2_d));
  ptc_delay #(.W(20), .N(10)) u_dly_rp (
    .clk(clk), .en(adv), .d(sample.raw_pressure), .q(rp10)
  );

  assign pbase = ptc_pkg::RAW_FULL - {1'b0, rp10};

  // Stage 10: dividend offset, divisor term; 11: dividend unscaled; 13: divisor
  always_ff @(posedge clk) begin
    if (adv) begin
      v2      <= vvp6 + (v1p5_d << 17) + (p4 << 35);
      v1b     <= 64'($signed(vvp3) >>> 8) + (v1p2_d << 12) + ptc_pkg::V1_BIAS;
      num_pre <= ({43'b0, pbase} << 31) - v2;
      den     <= 64'($signed(v1c_prod) >>> 33);
    end
  end

  ptc_mul64 u_mul_p1  (.clk(clk), .en(adv), .a(v1b), .b(p1), .p(v1c_prod));
  ptc_mul64 u_mul_sc  (.clk(clk), .en(adv), .a(num_pre), .b(ptc_pkg::PRES_SCALE), .p(num));

  // Zero divisor flag travels alongside the divider
  ptc_delay #(.W(1), .N(71)) u_dly_zero (
    .clk(clk), .en(adv), .d(den == 64'd0), .q(zero84)
  );

  ptc_div64 u_div (.clk(clk), .en(adv), .num(num), .den(den), .quo(q));

  assign h = 64'($signed(q) >>> 13);

  ptc_mul64 u_mul_hh  (.clk(clk), .en(adv), .a(h),  .b(h),  .p(hh));
  ptc_mul64 u_mul_p8  (.clk(clk), .en(adv), .a(q),  .b(p8), .p(w2));
  ptc_mul64 u_mul_p9  (.clk(clk), .en(adv), .a(hh), .b(p9), .p(w1));

  ptc_delay #(.W(64), .N(2)) u_dly_w2 (.clk(clk), .en(adv), .d(w2), .q(w2_d));
  ptc_delay #(.W(64), .N(4)) u_dly_q  (.clk(clk), .en(adv), .d(q),  .q(q_d));

  assign s_sh = 64'($signed(s84) >>> 8);

  // Stage 84: correction sum; stage 85: final scale and offset, output register
  always_ff @(posedge clk) begin
    if (adv) begin
      s84    <= q_d + 64'($signed(w1) >>> 25) + 64'($signed(w2_d) >>> 19);
      pres   <= zero84 ? '0 : 32'(s_sh + (p7 << 4));
      pvalid <= !zero84;
    end
  end

  // Temperature results ride along to the output register
  logic [31:0] fine85;
  logic [23:0] centi85;

  ptc_delay #(.W(32), .N(81)) u_dly_fine  (.clk(clk), .en(adv), .d(fine4),  .q(fine85));
  ptc_delay #(.W(24), .N(80)) u_dly_centi (.clk(clk), .en(adv), .d(centi5), .q(centi85));

  assign result.valid             = vld[ptc_pkg::PIPE_DEPTH];
  assign result.fine_temperature  = fine85;
  assign result.temperature_centi = centi85;
  assign result.pressure_q24_8    = pres;
  assign result.pressure_valid    = pvalid;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_reset_empty: assert property (@(posedge clk) rst |=> !result.valid)
    else $error("result valid right after reset");

  a_enter: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> vld[1])
    else $error("accepted item did not enter the pipeline");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved during a stall");

  a_zero_pres: assert property (@(posedge clk) disable iff (rst)
    result.valid && !result.pressure_valid |-> result.pressure_q24_8 == '0)
    else $error("nonzero pressure with zero divisor");

endmodule
